[design/spr_pkg.sv]
// Shared types and constants for the sample playback resampler.
// No dependencies; imported by sample_playback_resampler_core.
package spr_pkg;

    // Field and register widths.
    localparam int SMP_W      = 16;
    localparam int ADDR_IN_W  = 16;
    localparam int POS_W      = 40;
    localparam int FRAC_W     = 24;
    localparam int IDX_W      = POS_W - FRAC_W;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 17;
    localparam int PITCH_W    = 24;
    localparam int RATE_W     = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = ADDR_IN_W + SMP_W;
    localparam int OUT_DATA_W = SMP_W;
    localparam int INTEG_W    = 24;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_DEPTH_DEF      = 65536;
    localparam int OVERSAMPLE_FACTOR_DEF = 64;
    localparam int FILTER_STAGES_DEF     = 2;

    // Register reset values.
    localparam int COUNT_RST = 1;
    localparam int PITCH_RST = 65536;
    localparam int FILE_RST  = 48000;
    localparam int BASE_RST  = 30000;
    localparam int HOST_RST  = 48000;

    // Arithmetic constants.
    localparam int SMP_MAX    = 32767;
    localparam int SMP_MIN    = -32768;
    localparam int INTEG_MAX  = 8388607;
    localparam int INTEG_MIN  = -8388608;
    localparam int FB_STEP    = 32768;
    localparam int DS_LEVEL   = 4194304;
    localparam int DECIM_COEF = 3277;
    localparam int DECIM_RND  = 32768;
    localparam int TICK_LIMIT = 1024;
    localparam int TICK_LIM_W = 11;

    localparam logic CMD_WRITE   = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_CUBIC       = 2'd0,
        MODE_PITCH_HOLD  = 2'd1,
        MODE_FIXED_HOLD  = 2'd2,
        MODE_DELTA_SIGMA = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 3'd0,
        CFG_COUNT     = 3'd1,
        CFG_PITCH     = 3'd2,
        CFG_FILE_RATE = 3'd3,
        CFG_BASE_RATE = 3'd4,
        CFG_HOST_RATE = 3'd5
    } t_cfg_idx;

endpackage

[design/spr_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used by sample_playback_resampler_core for rate ratios.
module spr_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 25
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   rem_n;

    always_comb begin
        trial = {r_rem, r_q[NUM_W-1]};
        ge    = trial >= {1'b0, r_den};
        rem_n = ge ? (trial - {1'b0, r_den}) : trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_q    <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_cnt  <= CW'(NUM_W);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], ge};
            r_rem <= rem_n[DEN_W-1:0];
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

[design/sample_playback_resampler_core.sv]
// Top level of the sample playback resampler: sample memory, mode sequencer, datapath.
// Depends on spr_pkg and spr_div.
//
// Channel   | Direction | Handshake              | Content
// s_axis    | in        | tvalid/tready          | tuser command, tdata address + sample
// m_axis    | out       | tvalid/tready          | tdata output sample
// cfg       | in        | i_cfg_valid/o_cfg_ready| register index + write data
//
// A request runs the bit-serial divider (NUM_W is 50 at the defaults) once in cubic mode
// and twice in the hold and delta-sigma modes. Reset is synchronous; the sample memory
// is not cleared. Items are taken only in idle, while a finished result may still wait
// in the output register for m_axis_tready.
module sample_playback_resampler_core #(
    parameter int SAMPLE_DEPTH      = spr_pkg::SAMPLE_DEPTH_DEF,
    parameter int OVERSAMPLE_FACTOR = spr_pkg::OVERSAMPLE_FACTOR_DEF,
    parameter int FILTER_STAGES     = spr_pkg::FILTER_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] address, [31:16] sample_in
    input  logic [spr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] sample_out
    output logic [spr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [spr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spr_pkg::*;

    localparam int AW     = $clog2(SAMPLE_DEPTH);
    localparam int OF_W   = $clog2(OVERSAMPLE_FACTOR + 1);
    localparam int DEN_W  = RATE_W + OF_W;
    localparam int PROD_W = PITCH_W + RATE_W;
    localparam int NUM_A  = PROD_W + 8;
    localparam int NUM_W  = (DEN_W + FRAC_W > NUM_A) ? DEN_W + FRAC_W : NUM_A;
    localparam int TICK_W = NUM_W + 1 - FRAC_W;
    localparam int CNT_W  = $clog2(TICK_W);
    localparam int IX_W   = IDX_W + 3;
    localparam int ACC_W  = 32;
    localparam int SW     = INTEG_W + 2;
    localparam int FP_W   = 40;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [21:0] {
        S_IDLE    = 22'h000001,
        S_PREP    = 22'h000002,
        S_DVA     = 22'h000004,
        S_DVA_W   = 22'h000008,
        S_DVB     = 22'h000010,
        S_DVB_W   = 22'h000020,
        S_CB_RD   = 22'h000040,
        S_CB_WAIT = 22'h000080,
        S_CB_COEF = 22'h000100,
        S_CB_HORN = 22'h000200,
        S_CB_OUT  = 22'h000400,
        S_HOLD    = 22'h000800,
        S_HMUL    = 22'h001000,
        S_HPOS    = 22'h002000,
        S_HRD     = 22'h004000,
        S_HCAP    = 22'h008000,
        S_DS_PH   = 22'h010000,
        S_DS_RD   = 22'h020000,
        S_DS_INT  = 22'h040000,
        S_DS_FLT  = 22'h080000,
        S_DS_OUT  = 22'h100000,
        S_DONE    = 22'h200000
    } t_state;

    function automatic logic [POS_W-1:0] pos_add(input logic [POS_W-1:0] p,
                                                 input logic [NUM_W-1:0] d);
        logic [NUM_W:0] s;
        s = (NUM_W+1)'(p) + (NUM_W+1)'(d);
        if (s > (NUM_W+1)'(POS_MAX)) return POS_MAX;
        return s[POS_W-1:0];
    endfunction

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(SMP_MAX)) return SMP_W'(SMP_MAX);
        if (v < ACC_W'(SMP_MIN)) return SMP_W'(SMP_MIN);
        return v[SMP_W-1:0];
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat24(input logic signed [SW-1:0] v);
        if (v > SW'(INTEG_MAX)) return INTEG_W'(INTEG_MAX);
        if (v < SW'(INTEG_MIN)) return INTEG_W'(INTEG_MIN);
        return v[INTEG_W-1:0];
    endfunction

    // Configuration registers.
    t_mode              r_mode;
    logic [COUNT_W-1:0] r_count;
    logic [PITCH_W-1:0] r_pitch;
    logic [RATE_W-1:0]  r_file;
    logic [RATE_W-1:0]  r_base;
    logic [RATE_W-1:0]  r_host;

    // Sequencer and datapath state.
    t_state                    r_state;
    logic [POS_W-1:0]          r_pos;
    logic [FRAC_W-1:0]         r_tphase;
    logic                      r_first;
    logic signed [SMP_W-1:0]   r_held;
    logic [FRAC_W-1:0]         r_osp;
    logic signed [INTEG_W-1:0] r_integ;
    logic                      r_fb_nz;
    logic                      r_fb_neg;
    logic signed [INTEG_W-1:0] r_stage [FILTER_STAGES];
    logic signed [INTEG_W-1:0] r_dsx;
    logic [TICK_LIM_W-1:0]     r_dsleft;
    logic [PROD_W-1:0]         r_prod;
    logic [NUM_W-1:0]          r_inc;
    logic [NUM_W-1:0]          r_step;
    logic [CNT_W-1:0]          r_cnt;
    logic [TICK_W-1:0]         r_ticks;
    logic [POS_W-1:0]          r_macc;
    logic                      r_msat;
    logic                      r_cap;
    logic signed [SMP_W-1:0]   r_y [4];
    logic signed [19:0]        r_c1;
    logic signed [19:0]        r_c2;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SMP_W-1:0]   r_res;
    logic signed [SMP_W-1:0]   r_out_data;
    logic                      r_out_valid;

    // Sample memory.
    logic signed [SMP_W-1:0] r_mem [SAMPLE_DEPTH];
    logic signed [SMP_W-1:0] r_rd_data;

    logic                  in_xfer;
    logic                  cfg_xfer;
    logic                  mem_we;
    logic [ADDR_IN_W-1:0]  s_addr;
    logic [SMP_W-1:0]      s_smp;
    logic [RATE_W-1:0]     file_nz;
    logic [RATE_W-1:0]     base_nz;
    logic [RATE_W-1:0]     host_nz;
    logic [RATE_W-1:0]     mul_sel;
    logic [DEN_W-1:0]      base_of;
    logic [COUNT_W-1:0]    count_nz;
    logic [COUNT_W-1:0]    len;
    logic [IX_W-1:0]       pos_ix;
    logic [IX_W-1:0]       rd_ix;
    logic [IX_W-1:0]       len_m1;
    logic [IX_W-1:0]       rd_cl;
    logic [AW-1:0]         rd_addr;
    logic                  div_start;
    logic                  div_busy;
    logic                  div_done;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic [NUM_W-1:0]      div_quot;
    logic [NUM_W:0]        hsum;
    logic [NUM_W:0]        dsum;
    logic [TICK_W-1:0]     dticks;
    logic [NUM_W+1:0]      mtrial;
    logic signed [19:0]    y0e, y1e, y2e, y3e, c0, c1, c2;
    logic signed [FRAC_W:0]          frac_s;
    logic signed [ACC_W+FRAC_W:0]    hprod;
    logic signed [ACC_W-1:0]         addend;
    logic signed [ACC_W-1:0]         cb_fin;
    logic signed [ACC_W-1:0]         ds_fin;
    logic signed [SW-1:0]            fbterm;
    logic signed [SW-1:0]            isum;
    logic signed [INTEG_W-1:0]       isat;
    logic signed [SW-1:0]            st_e;
    logic signed [SW-1:0]            dif;
    logic signed [FP_W-1:0]          fprod;
    logic signed [INTEG_W-1:0]       fsat;

    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_xfer      = i_cfg_valid && o_cfg_ready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign s_addr        = s_axis_tdata[ADDR_IN_W-1:0];
    assign s_smp         = s_axis_tdata[IN_DATA_W-1:ADDR_IN_W];
    assign mem_we        = in_xfer && (s_axis_tuser == CMD_WRITE)
                           && (32'(s_addr) < SAMPLE_DEPTH);
    assign div_start     = (r_state == S_DVA) || (r_state == S_DVB);

    always_comb begin
        file_nz  = (r_file == '0) ? RATE_W'(1) : r_file;
        base_nz  = (r_base == '0) ? RATE_W'(1) : r_base;
        host_nz  = (r_host == '0) ? RATE_W'(1) : r_host;
        count_nz = (r_count == '0) ? COUNT_W'(1) : r_count;
        len      = (32'(count_nz) > SAMPLE_DEPTH) ? COUNT_W'(SAMPLE_DEPTH) : count_nz;
        base_of  = DEN_W'(base_nz) * DEN_W'(OVERSAMPLE_FACTOR);

        // Delta-sigma: file rate raw. Others treat zero as one; pitch hold uses the base rate.
        case (r_mode)
            MODE_PITCH_HOLD:  mul_sel = base_nz;
            MODE_DELTA_SIGMA: mul_sel = r_file;
            default:          mul_sel = file_nz;
        endcase

        if (r_state == S_DVA) begin
            div_den = DEN_W'(host_nz);
            case (r_mode)
                MODE_FIXED_HOLD:  div_num = NUM_W'({base_nz, {FRAC_W{1'b0}}});
                MODE_DELTA_SIGMA: div_num = NUM_W'({base_of, {FRAC_W{1'b0}}});
                default:          div_num = NUM_W'({r_prod, 8'b0});
            endcase
        end else begin
            div_den = (r_mode == MODE_DELTA_SIGMA) ? base_of : DEN_W'(base_nz);
            if (r_mode == MODE_PITCH_HOLD) begin
                div_num = NUM_W'({file_nz, {FRAC_W{1'b0}}});
            end else begin
                div_num = NUM_W'({r_prod, 8'b0});
            end
        end

        // Read index, clamped to the loaded length.
        pos_ix = IX_W'(r_pos[POS_W-1:FRAC_W]);
        if (r_state == S_CB_RD) begin
            rd_ix = pos_ix + IX_W'(r_cnt) - IX_W'(1);
        end else begin
            rd_ix = pos_ix;
        end
        len_m1 = IX_W'(len) - IX_W'(1);
        if (rd_ix[IX_W-1]) begin
            rd_cl = '0;
        end else if (rd_ix > len_m1) begin
            rd_cl = len_m1;
        end else begin
            rd_cl = rd_ix;
        end
        rd_addr = AW'(rd_cl);

        hsum   = (NUM_W+1)'(r_tphase) + (NUM_W+1)'(r_inc);
        dsum   = (NUM_W+1)'(r_osp) + (NUM_W+1)'(r_inc);
        dticks = dsum[NUM_W:FRAC_W];
        mtrial = (NUM_W+2)'({r_macc, 1'b0})
                 + (r_ticks[TICK_W-1] ? (NUM_W+2)'(r_step) : '0);

        // Catmull-Rom coefficients, doubled to integers.
        y0e = 20'(r_y[0]);
        y1e = 20'(r_y[1]);
        y2e = 20'(r_y[2]);
        y3e = 20'(r_y[3]);
        c0  = -y0e + 20'sd3 * y1e - 20'sd3 * y2e + y3e;
        c1  = 20'sd2 * y0e - 20'sd5 * y1e + 20'sd4 * y2e - y3e;
        c2  = y2e - y0e;

        frac_s = $signed({1'b0, r_pos[FRAC_W-1:0]});
        hprod  = r_acc * frac_s;
        case (r_cnt)
            CNT_W'(0): addend = ACC_W'(r_c1) <<< 8;
            CNT_W'(1): addend = ACC_W'(r_c2) <<< 8;
            default:   addend = ACC_W'(r_y[1]) <<< 9;
        endcase
        cb_fin = (r_acc + ACC_W'(256)) >>> 9;
        ds_fin = (ACC_W'(r_stage[FILTER_STAGES-1]) + ACC_W'(64)) >>> 7;

        // First-order modulator with a saturating integrator.
        if (!r_fb_nz) begin
            fbterm = '0;
        end else if (r_fb_neg) begin
            fbterm = -SW'(FB_STEP);
        end else begin
            fbterm = SW'(FB_STEP);
        end
        isum = SW'(r_integ) + SW'(r_rd_data) - fbterm;
        isat = sat24(isum);

        // One lowpass stage per cycle; stage 0 of the rotating array is the one in work.
        st_e  = SW'(r_stage[0]);
        dif   = SW'(r_dsx) - st_e;
        fprod = FP_W'(dif) * FP_W'(DECIM_COEF) + FP_W'(DECIM_RND);
        fsat  = sat24(st_e + SW'(fprod >>> 16));
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[AW'(s_addr)] <= s_smp;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    spr_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_CUBIC;
            r_count     <= COUNT_W'(COUNT_RST);
            r_pitch     <= PITCH_W'(PITCH_RST);
            r_file      <= RATE_W'(FILE_RST);
            r_base      <= RATE_W'(BASE_RST);
            r_host      <= RATE_W'(HOST_RST);
            r_pos       <= '0;
            r_tphase    <= '0;
            r_first     <= 1'b1;
            r_held      <= '0;
            r_osp       <= '0;
            r_integ     <= '0;
            r_fb_nz     <= 1'b0;
            r_fb_neg    <= 1'b0;
            r_dsleft    <= '0;
            r_cnt       <= '0;
            r_cap       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < FILTER_STAGES; i++) begin
                r_stage[i] <= '0;
            end
        end else begin
            // Read data arrives in the cycle after the address, so the window shifts late.
            r_cap <= (r_state == S_CB_RD);
            if (r_cap) begin
                r_y[3] <= r_rd_data;
                for (int i = 0; i < 3; i++) begin
                    r_y[i] <= r_y[i+1];
                end
            end

            if (cfg_xfer) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_MODE:      r_mode  <= t_mode'(i_cfg_data[MODE_W-1:0]);
                    CFG_COUNT:     r_count <= i_cfg_data[COUNT_W-1:0];
                    CFG_PITCH:     r_pitch <= i_cfg_data[PITCH_W-1:0];
                    CFG_FILE_RATE: r_file  <= i_cfg_data[RATE_W-1:0];
                    CFG_BASE_RATE: r_base  <= i_cfg_data[RATE_W-1:0];
                    CFG_HOST_RATE: r_host  <= i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end

            // In S_DONE the output register is reloaded instead.
            if (m_axis_tvalid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (s_axis_tuser == CMD_REQUEST)) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_prod  <= PROD_W'(r_pitch) * PROD_W'(mul_sel);
                    r_state <= S_DVA;
                end
                S_DVA: r_state <= S_DVA_W;
                S_DVA_W: begin
                    if (div_done) begin
                        if (r_mode == MODE_CUBIC) begin
                            r_step  <= div_quot;
                            r_cnt   <= '0;
                            r_state <= S_CB_RD;
                        end else begin
                            r_inc   <= div_quot;
                            r_state <= S_DVB;
                        end
                    end
                end
                S_DVB: r_state <= S_DVB_W;
                S_DVB_W: begin
                    if (div_done) begin
                        r_step  <= div_quot;
                        r_state <= (r_mode == MODE_DELTA_SIGMA) ? S_DS_PH : S_HOLD;
                    end
                end
                S_CB_RD: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(3)) begin
                        r_state <= S_CB_WAIT;
                    end
                end
                S_CB_WAIT: r_state <= S_CB_COEF;
                S_CB_COEF: begin
                    r_acc   <= ACC_W'(c0) <<< 8;
                    r_c1    <= c1;
                    r_c2    <= c2;
                    r_cnt   <= '0;
                    r_state <= S_CB_HORN;
                end
                S_CB_HORN: begin
                    r_acc <= ACC_W'(hprod >>> FRAC_W) + addend;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(2)) begin
                        r_state <= S_CB_OUT;
                    end
                end
                S_CB_OUT: begin
                    r_res   <= sat16(cb_fin);
                    r_pos   <= pos_add(r_pos, r_step);
                    r_state <= S_DONE;
                end
                S_HOLD: begin
                    r_tphase <= hsum[FRAC_W-1:0];
                    r_ticks  <= hsum[NUM_W:FRAC_W];
                    r_first  <= 1'b0;
                    r_macc   <= '0;
                    r_msat   <= 1'b0;
                    r_cnt    <= '0;
                    // Only the read at the final position matters.
                    if (hsum[NUM_W:FRAC_W] != '0) begin
                        r_state <= S_HMUL;
                    end else if (r_first) begin
                        r_state <= S_HRD;
                    end else begin
                        r_res   <= r_held;
                        r_state <= S_DONE;
                    end
                end
                S_HMUL: begin
                    // Shift-and-add of ticks times step, saturating once past the position range.
                    r_ticks <= r_ticks << 1;
                    if (r_msat || (mtrial > (NUM_W+2)'(POS_MAX))) begin
                        r_msat <= 1'b1;
                    end else begin
                        r_macc <= mtrial[POS_W-1:0];
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(TICK_W - 1)) begin
                        r_state <= S_HPOS;
                    end
                end
                S_HPOS: begin
                    r_pos   <= r_msat ? POS_MAX : pos_add(r_pos, NUM_W'(r_macc));
                    r_state <= S_HRD;
                end
                S_HRD: r_state <= S_HCAP;
                S_HCAP: begin
                    r_held  <= r_rd_data;
                    r_res   <= r_rd_data;
                    r_state <= S_DONE;
                end
                S_DS_PH: begin
                    r_osp <= dsum[FRAC_W-1:0];
                    if (dticks > TICK_W'(TICK_LIMIT)) begin
                        r_dsleft <= TICK_LIM_W'(TICK_LIMIT);
                    end else begin
                        r_dsleft <= TICK_LIM_W'(dticks);
                    end
                    r_state <= (dticks == '0) ? S_DS_OUT : S_DS_RD;
                end
                S_DS_RD: begin
                    r_pos   <= pos_add(r_pos, r_step);
                    r_state <= S_DS_INT;
                end
                S_DS_INT: begin
                    r_integ  <= isat;
                    r_fb_nz  <= 1'b1;
                    r_fb_neg <= isat[INTEG_W-1];
                    r_dsx    <= isat[INTEG_W-1] ? -INTEG_W'(DS_LEVEL) : INTEG_W'(DS_LEVEL);
                    r_cnt    <= '0;
                    r_state  <= S_DS_FLT;
                end
                S_DS_FLT: begin
                    for (int i = 0; i < FILTER_STAGES - 1; i++) begin
                        r_stage[i] <= r_stage[i+1];
                    end
                    r_stage[FILTER_STAGES-1] <= fsat;
                    r_dsx <= fsat;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(FILTER_STAGES - 1)) begin
                        r_dsleft <= r_dsleft - TICK_LIM_W'(1);
                        r_state  <= (r_dsleft == TICK_LIM_W'(1)) ? S_DS_OUT : S_DS_RD;
                    end
                end
                S_DS_OUT: begin
                    r_res   <= sat16(ds_fin);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_data  <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_tick_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dsleft <= TICK_LIM_W'(TICK_LIMIT))
        else $error("delta-sigma tick count above limit");

    a_filter_after_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DS_FLT) |-> r_fb_nz)
        else $error("filter stage ran before a modulator decision");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_out_valid || m_axis_tready))
        |=> (m_axis_tvalid && (m_axis_tdata == $past(r_res))))
        else $error("finished result not presented");

endmodule
